/* design/gpio_expander_irq_counter_defines.svh */
// assertion macros shared by the expander queue and back modules
// each macro samples on clk and is disabled while arst_n is low
`ifndef GPIO_EXPANDER_IRQ_COUNTER_DEFINES_SVH
`define GPIO_EXPANDER_IRQ_COUNTER_DEFINES_SVH

// condition holds at every edge
`define GPX_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define GPX_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define GPX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/gpx_pkg.sv */
// types and constants of the gpio expander command engine
// no dependencies
package gpx_pkg;

	localparam int NUM_PINS    = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] LOW_GROUP  = 8'h3F;
	localparam logic [7:0] HIGH_GROUP = 8'hC0;
	localparam logic [7:0] HIGH_RAW   = 8'h03;
	localparam logic [7:0] DIR_RESET  = 8'hFF;
	localparam logic [7:0] FW_TYPE_ID = 8'h01;
	localparam logic [7:0] FW_VER_ID  = 8'h01;
	localparam logic [7:0] BAD_INDEX  = 8'hFF;
	localparam logic [7:0] LAST_INDEX = 8'h07;

	localparam logic [1:0] LEN_NONE = 2'd0;
	localparam logic [1:0] LEN_ONE  = 2'd1;
	localparam logic [1:0] LEN_TWO  = 2'd2;

	typedef enum logic [3:0] {
		OP_SET_DIR    = 4'd0,
		OP_SET_OUT    = 4'd1,
		OP_GET_PINS   = 4'd2,
		OP_SET_IRQ_EN = 4'd3,
		OP_GET_FLAGS  = 4'd4,
		OP_SET_PULLUP = 4'd5,
		OP_GET_COUNT  = 4'd6,
		OP_RESET      = 4'd7,
		OP_FW_TYPE    = 4'd8,
		OP_FW_VER     = 4'd9,
		OP_EVENT_LOW  = 4'd10,
		OP_EVENT_HIGH = 4'd11
	} op_t;

	typedef enum logic [3:0] {
		K_NOP,
		K_WR_DIR,
		K_WR_OUT,
		K_WR_IRQ,
		K_WR_PULL,
		K_RD_PINS,
		K_RD_FLAGS,
		K_RD_COUNT,
		K_CLEAR,
		K_FW_TYPE,
		K_FW_VER,
		K_EVENT
	} kind_t;

	// one classified word handed from front to back
	typedef struct packed {
		kind_t      kind;
		logic [7:0] arg;
		logic [7:0] levels;
		logic [7:0] pend;
		logic [7:0] keep;
		logic       idx_ok;
	} cmd_t;

endpackage

/* design/gpx_front.sv */
// front stage: accepts words, decodes the op and prepares event masks
// depends on gpx_pkg
module gpx_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [3:0]    op,
	input  logic [7:0]    arg_byte,
	input  logic [7:0]    pin_levels,
	output logic          push,
	output gpx_pkg::cmd_t push_data,
	input  logic          q_full
);

	logic          valid_s1;
	gpx_pkg::cmd_t cmd_s1;
	gpx_pkg::cmd_t cmd_d;
	logic          take;

	assign in_stall  = valid_s1 && q_full;
	assign take      = in_valid && !in_stall;
	assign push      = valid_s1 && !q_full;
	assign push_data = cmd_s1;

	always_comb begin
		cmd_d.kind   = gpx_pkg::K_NOP;
		cmd_d.arg    = arg_byte;
		cmd_d.levels = pin_levels;
		cmd_d.pend   = '0;
		cmd_d.keep   = '1;
		cmd_d.idx_ok = (arg_byte <= gpx_pkg::LAST_INDEX);
		unique case (gpx_pkg::op_t'(op))
			gpx_pkg::OP_SET_DIR:    cmd_d.kind = gpx_pkg::K_WR_DIR;
			gpx_pkg::OP_SET_OUT:    cmd_d.kind = gpx_pkg::K_WR_OUT;
			gpx_pkg::OP_GET_PINS:   cmd_d.kind = gpx_pkg::K_RD_PINS;
			gpx_pkg::OP_SET_IRQ_EN: cmd_d.kind = gpx_pkg::K_WR_IRQ;
			gpx_pkg::OP_GET_FLAGS:  cmd_d.kind = gpx_pkg::K_RD_FLAGS;
			gpx_pkg::OP_SET_PULLUP: cmd_d.kind = gpx_pkg::K_WR_PULL;
			gpx_pkg::OP_GET_COUNT:  cmd_d.kind = gpx_pkg::K_RD_COUNT;
			gpx_pkg::OP_RESET:      cmd_d.kind = gpx_pkg::K_CLEAR;
			gpx_pkg::OP_FW_TYPE:    cmd_d.kind = gpx_pkg::K_FW_TYPE;
			gpx_pkg::OP_FW_VER:     cmd_d.kind = gpx_pkg::K_FW_VER;
			gpx_pkg::OP_EVENT_LOW: begin
				cmd_d.kind = gpx_pkg::K_EVENT;
				cmd_d.pend = arg_byte & gpx_pkg::LOW_GROUP;
				cmd_d.keep = gpx_pkg::HIGH_GROUP;
			end
			gpx_pkg::OP_EVENT_HIGH: begin
				cmd_d.kind = gpx_pkg::K_EVENT;
				// pins 6 and 7 arrive in the two low arg bits
				cmd_d.pend = {arg_byte[1:0] & gpx_pkg::HIGH_RAW[1:0], 6'd0};
				cmd_d.keep = gpx_pkg::LOW_GROUP;
			end
			default:                cmd_d.kind = gpx_pkg::K_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

/* design/gpx_queue.sv */
// short fifo between the decode front and the execute back
// depends on gpx_pkg and the assertion macro header
`include "gpio_expander_irq_counter_defines.svh"

module gpx_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gpx_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output gpx_pkg::cmd_t pop_data
);

	localparam int Depth = gpx_pkg::QUEUE_DEPTH;
	localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW  = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	gpx_pkg::cmd_t   slot_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full     = (count_q == FullCnt);
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	`GPX_ASSERT_ALWAYS(a_count_bound, count_q <= FullCnt, "queue count above depth")
	`GPX_ASSERT_SAME(a_no_pop_empty, pop, !empty, "pop from empty queue")
	`GPX_ASSERT_SAME(a_no_push_full, push, !full, "push into full queue")
	`GPX_ASSERT_NEXT(a_count_track, push && !pop, count_q == $past(count_q) + 1'b1,
		"queue count missed a push")

endmodule

/* design/gpx_back.sv */
// execute stage: register file, flags, event counters and result register
// depends on gpx_pkg and the assertion macro header
`include "gpio_expander_irq_counter_defines.svh"

module gpx_back #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  gpx_pkg::cmd_t q_data,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    pin_direction,
	output logic [7:0]    pin_drive,
	output logic [7:0]    pin_pullup,
	output logic [1:0]    reply_length,
	output logic [7:0]    reply_first,
	output logic [7:0]    reply_second
);

	localparam int Pins = gpx_pkg::NUM_PINS;

	logic [7:0] dir_q, drive_q, pull_q, irq_en_q, flag_q;
	logic [COUNT_WIDTH-1:0] cnt_q [Pins];

	logic [7:0] dir_d, drive_d, pull_d, irq_en_d, flag_d;
	logic [7:0] hits;
	logic       clear;
	logic [1:0] len_d;
	logic [7:0] first_d, second_d;
	logic [15:0] cnt16;

	logic       out_valid_q;
	logic [7:0] dir_s3, drive_s3, pull_s3, first_s3, second_s3;
	logic [1:0] len_s3;

	assign pop = !q_empty && (!out_valid_q || !out_stall);

	// count bits above 15 are not reported, missing ones read as zero
	assign cnt16 = 16'(cnt_q[q_data.arg[2:0]]);

	always_comb begin
		dir_d    = dir_q;
		drive_d  = drive_q;
		pull_d   = pull_q;
		irq_en_d = irq_en_q;
		flag_d   = flag_q;
		hits     = '0;
		clear    = 1'b0;
		len_d    = gpx_pkg::LEN_NONE;
		first_d  = '0;
		second_d = '0;
		unique case (q_data.kind)
			gpx_pkg::K_WR_DIR:  dir_d    = q_data.arg;
			gpx_pkg::K_WR_OUT:  drive_d  = q_data.arg;
			gpx_pkg::K_WR_IRQ:  irq_en_d = q_data.arg;
			gpx_pkg::K_WR_PULL: pull_d   = q_data.arg;
			gpx_pkg::K_RD_PINS: begin
				len_d   = gpx_pkg::LEN_ONE;
				first_d = q_data.levels & ~dir_q;
			end
			gpx_pkg::K_RD_FLAGS: begin
				len_d   = gpx_pkg::LEN_ONE;
				first_d = flag_q;
				flag_d  = '0;
			end
			gpx_pkg::K_RD_COUNT: begin
				len_d = gpx_pkg::LEN_TWO;
				if (q_data.idx_ok) begin
					first_d  = cnt16[15:8];
					second_d = cnt16[7:0];
				end else begin
					first_d  = gpx_pkg::BAD_INDEX;
					second_d = gpx_pkg::BAD_INDEX;
				end
			end
			gpx_pkg::K_CLEAR: begin
				clear    = 1'b1;
				dir_d    = gpx_pkg::DIR_RESET;
				drive_d  = '0;
				pull_d   = '0;
				irq_en_d = '0;
				flag_d   = '0;
			end
			gpx_pkg::K_FW_TYPE: begin
				len_d   = gpx_pkg::LEN_ONE;
				first_d = gpx_pkg::FW_TYPE_ID;
			end
			gpx_pkg::K_FW_VER: begin
				len_d   = gpx_pkg::LEN_ONE;
				first_d = gpx_pkg::FW_VER_ID;
			end
			gpx_pkg::K_EVENT: begin
				hits   = q_data.pend & irq_en_q;
				flag_d = (flag_q & q_data.keep) | hits;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q    <= gpx_pkg::DIR_RESET;
			drive_q  <= '0;
			pull_q   <= '0;
			irq_en_q <= '0;
			flag_q   <= '0;
			for (int i = 0; i < Pins; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (pop) begin
			dir_q    <= dir_d;
			drive_q  <= drive_d;
			pull_q   <= pull_d;
			irq_en_q <= irq_en_d;
			flag_q   <= flag_d;
			for (int i = 0; i < Pins; i++) begin
				if (clear) begin
					cnt_q[i] <= '0;
				end else if (hits[i]) begin
					cnt_q[i] <= cnt_q[i] + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dir_s3    <= dir_d;
			drive_s3  <= drive_d;
			pull_s3   <= pull_d;
			len_s3    <= len_d;
			first_s3  <= first_d;
			second_s3 <= second_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign pin_direction = dir_s3;
	assign pin_drive     = drive_s3;
	assign pin_pullup    = pull_s3;
	assign reply_length  = len_s3;
	assign reply_first   = first_s3;
	assign reply_second  = second_s3;

	`GPX_ASSERT_SAME(a_len_range, out_valid_q, len_s3 != 2'd3, "reply length out of range")
	`GPX_ASSERT_SAME(a_no_reply_zero, out_valid_q && len_s3 == gpx_pkg::LEN_NONE,
		first_s3 == '0 && second_s3 == '0, "reply bytes set without reply")
	`GPX_ASSERT_NEXT(a_flags_cleared, pop && q_data.kind == gpx_pkg::K_RD_FLAGS,
		flag_q == '0, "flags not cleared by flag read")
	`GPX_ASSERT_NEXT(a_clear_dir, pop && q_data.kind == gpx_pkg::K_CLEAR,
		dir_q == gpx_pkg::DIR_RESET && irq_en_q == '0, "reset command left state")

endmodule

/* design/gpio_expander_irq_counter.sv */
// path: an accepted word is registered in the decode register, then in a queue slot, then in
// the result register; a full queue or out_stall can hold a word at any of these
// throughput: one word per cycle while neither a full queue nor out_stall holds the flow
// reset: asynchronous, all pins outputs, other registers, flags and counters zero
// top level of the expander command engine, built from front, queue and back
// depends on gpx_pkg, gpx_front, gpx_queue and gpx_back
module gpio_expander_irq_counter #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [3:0] op,
	input  logic [7:0] arg_byte,
	input  logic [7:0] pin_levels,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] pin_direction,
	output logic [7:0] pin_drive,
	output logic [7:0] pin_pullup,
	output logic [1:0] reply_length,
	output logic [7:0] reply_first,
	output logic [7:0] reply_second
);

	logic          push;
	gpx_pkg::cmd_t push_data;
	logic          q_full;
	logic          q_empty;
	logic          pop;
	gpx_pkg::cmd_t pop_data;

	gpx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.arg_byte   (arg_byte),
		.pin_levels (pin_levels),
		.push       (push),
		.push_data  (push_data),
		.q_full     (q_full)
	);

	gpx_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.pop_data  (pop_data)
	);

	gpx_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_data        (pop_data),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pin_direction (pin_direction),
		.pin_drive     (pin_drive),
		.pin_pullup    (pin_pullup),
		.reply_length  (reply_length),
		.reply_first   (reply_first),
		.reply_second  (reply_second)
	);

endmodule

/* tb/testbench.sv */
// self-checking testbench for gpio_expander_irq_counter: directed commands,
// then biased random words, with random idling and stalls on both channels
// depends on gpx_pkg and the expander rtl
package expander_check_pkg;

	localparam int COUNT_W = 16;

	typedef struct packed {
		logic [7:0] dir;
		logic [7:0] drive;
		logic [7:0] pull;
		logic [1:0] len;
		logic [7:0] rep1;
		logic [7:0] rep2;
	} reply_t;

	class expander_scoreboard;
		logic [7:0]         dir_q;
		logic [7:0]         drive_q;
		logic [7:0]         pull_q;
		logic [7:0]         irq_en_q;
		logic [7:0]         flags_q;
		logic [COUNT_W-1:0] counts [gpx_pkg::NUM_PINS];
		reply_t             due_replies[$];
		int                 errors;

		function new();
			errors = 0;
			clear_regs();
		endfunction

		function void clear_regs();
			dir_q = gpx_pkg::DIR_RESET;
			drive_q = '0;
			pull_q = '0;
			irq_en_q = '0;
			flags_q = '0;
			foreach (counts[i]) counts[i] = '0;
		endfunction

		function void bump_counts(logic [7:0] hits);
			for (int i = 0; i < gpx_pkg::NUM_PINS; i++) begin
				if (hits[i]) counts[i] = counts[i] + 1'b1;
			end
		endfunction

		// predict the reply of an accepted command word
		function void note_word(logic [3:0] code, logic [7:0] arg, logic [7:0] levels);
			reply_t     r;
			logic [7:0] hits;
			logic [31:0] c;
			r.len = gpx_pkg::LEN_NONE;
			r.rep1 = '0;
			r.rep2 = '0;
			case (code)
				gpx_pkg::OP_SET_DIR: dir_q = arg;
				gpx_pkg::OP_SET_OUT: drive_q = arg;
				gpx_pkg::OP_SET_IRQ_EN: irq_en_q = arg;
				gpx_pkg::OP_SET_PULLUP: pull_q = arg;
				gpx_pkg::OP_GET_PINS: begin
					r.len = gpx_pkg::LEN_ONE;
					r.rep1 = levels & ~dir_q;
				end
				gpx_pkg::OP_GET_FLAGS: begin
					r.len = gpx_pkg::LEN_ONE;
					r.rep1 = flags_q;
					flags_q = '0;
				end
				gpx_pkg::OP_GET_COUNT: begin
					r.len = gpx_pkg::LEN_TWO;
					if (arg <= gpx_pkg::LAST_INDEX) begin
						c = 32'(counts[arg[2:0]]);
						r.rep1 = c[15:8];
						r.rep2 = c[7:0];
					end else begin
						r.rep1 = gpx_pkg::BAD_INDEX;
						r.rep2 = gpx_pkg::BAD_INDEX;
					end
				end
				gpx_pkg::OP_RESET: clear_regs();
				gpx_pkg::OP_FW_TYPE: begin
					r.len = gpx_pkg::LEN_ONE;
					r.rep1 = gpx_pkg::FW_TYPE_ID;
				end
				gpx_pkg::OP_FW_VER: begin
					r.len = gpx_pkg::LEN_ONE;
					r.rep1 = gpx_pkg::FW_VER_ID;
				end
				gpx_pkg::OP_EVENT_LOW: begin
					hits = arg & irq_en_q & gpx_pkg::LOW_GROUP;
					flags_q = (flags_q & gpx_pkg::HIGH_GROUP) | hits;
					bump_counts(hits);
				end
				gpx_pkg::OP_EVENT_HIGH: begin
					// pending bits for pins 6 and 7 sit in arg bits 1..0
					hits = ((arg & gpx_pkg::HIGH_RAW) << 6) & irq_en_q & gpx_pkg::HIGH_GROUP;
					flags_q = (flags_q & gpx_pkg::LOW_GROUP) | hits;
					bump_counts(hits);
				end
				default: ;
			endcase
			r.dir = dir_q;
			r.drive = drive_q;
			r.pull = pull_q;
			due_replies.push_back(r);
		endfunction

		function void compare_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
			if (got_v !== exp_v) begin
				$error("%s: expected %02h, got %02h", name, exp_v, got_v);
				errors++;
			end
		endfunction

		function void match_reply(reply_t got);
			reply_t exp_r;
			if (due_replies.size() == 0) begin
				$error("reply word with nothing expected");
				errors++;
				return;
			end
			exp_r = due_replies.pop_front();
			compare_field("pin_direction", exp_r.dir, got.dir);
			compare_field("pin_drive", exp_r.drive, got.drive);
			compare_field("pin_pullup", exp_r.pull, got.pull);
			compare_field("reply_length", 8'(exp_r.len), 8'(got.len));
			compare_field("reply_first", exp_r.rep1, got.rep1);
			compare_field("reply_second", exp_r.rep2, got.rep2);
		endfunction

		function int pending();
			return due_replies.size();
		endfunction
	endclass
endpackage

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_WORDS = 1700;
	localparam int CYCLE_LIMIT  = 400000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [3:0] op;
	logic [7:0] arg_byte;
	logic [7:0] pin_levels;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] pin_direction;
	logic [7:0] pin_drive;
	logic [7:0] pin_pullup;
	logic [1:0] reply_length;
	logic [7:0] reply_first;
	logic [7:0] reply_second;

	expander_check_pkg::expander_scoreboard book = new();
	int send_mode;
	int recv_mode;
	int cycles;

	gpio_expander_irq_counter #(.COUNT_WIDTH(expander_check_pkg::COUNT_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.arg_byte(arg_byte),
		.pin_levels(pin_levels),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pin_direction(pin_direction),
		.pin_drive(pin_drive),
		.pin_pullup(pin_pullup),
		.reply_length(reply_length),
		.reply_first(reply_first),
		.reply_second(reply_second)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// mode 0 never idles, mode 1 idles freely, mode 2 idles now and then
	function automatic int pick_wait(int mode);
		if (mode == 0) return 0;
		if (mode == 1) return $urandom_range(0, 15);
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_word(logic [3:0] code, logic [7:0] arg, logic [7:0] levels);
		int gap;
		gap = pick_wait(send_mode);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		arg_byte <= arg;
		pin_levels <= levels;
		do @(posedge clk); while (in_stall);
		book.note_word(code, arg, levels);
		@(negedge clk);
	endtask

	task automatic send_random_word();
		int         pick;
		logic [3:0] code;
		logic [7:0] arg;
		pick = $urandom_range(0, 99);
		arg = 8'($urandom_range(0, 255));
		if (pick < 28) begin
			code = gpx_pkg::OP_EVENT_LOW;
			if ($urandom_range(0, 1)) arg = 8'hFF;
		end else if (pick < 42) begin
			code = gpx_pkg::OP_EVENT_HIGH;
			if ($urandom_range(0, 1)) arg[1:0] = 2'b11;
		end else if (pick < 54) begin
			code = gpx_pkg::OP_GET_COUNT;
			if ($urandom_range(0, 4) != 0) arg = 8'($urandom_range(0, 7));
		end else if (pick < 62) code = gpx_pkg::OP_GET_FLAGS;
		else if (pick < 68) code = gpx_pkg::OP_GET_PINS;
		else if (pick < 72) code = gpx_pkg::OP_SET_DIR;
		else if (pick < 75) code = gpx_pkg::OP_SET_OUT;
		else if (pick < 78) code = gpx_pkg::OP_SET_PULLUP;
		else if (pick < 84) begin
			code = gpx_pkg::OP_SET_IRQ_EN;
			if ($urandom_range(0, 1)) arg = 8'hFF;
		end else if (pick < 86) code = gpx_pkg::OP_FW_TYPE;
		else if (pick < 88) code = gpx_pkg::OP_FW_VER;
		else if (pick < 92) code = 4'($urandom_range(12, 15));
		else code = 4'($urandom_range(0, 15));
		// a rare clear keeps counters long enough to reach the high byte
		if (code == gpx_pkg::OP_RESET && $urandom_range(0, 9) != 0) code = gpx_pkg::OP_GET_FLAGS;
		send_word(code, arg, 8'($urandom_range(0, 255)));
	endtask

	// result side: random stalls per word, plus long hold-offs to back up the pipe
	initial begin
		int n;
		int taken;
		out_stall = 1'b0;
		taken = 0;
		recv_mode = 1;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (taken % 50 == 0) recv_mode = $urandom_range(0, 2);
			if (taken == 300 || taken == 1000) begin
				out_stall <= 1'b1;
				repeat ((taken == 300) ? 200 : 60) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				n = pick_wait(recv_mode);
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(negedge clk);
					out_stall <= 1'b0;
				end
			end
			do @(posedge clk); while (!out_valid);
			taken++;
			@(negedge clk);
		end
	end

	always @(posedge clk) begin : monitor
		expander_check_pkg::reply_t got;
		got = '{pin_direction, pin_drive, pin_pullup, reply_length, reply_first, reply_second};
		if (arst_n && out_valid && !out_stall) book.match_reply(got);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("gpio_expander_irq_counter test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = gpx_pkg::OP_SET_DIR;
		arg_byte = '0;
		pin_levels = '0;
		send_mode = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset state, pin masking, flags, counters, unused codes
		send_word(gpx_pkg::OP_GET_PINS, 8'h00, 8'hFF);
		send_word(gpx_pkg::OP_FW_TYPE, 8'hFF, 8'h00);
		send_word(gpx_pkg::OP_FW_VER, 8'h00, 8'hFF);
		send_word(gpx_pkg::OP_SET_DIR, 8'h00, 8'h00);
		send_word(gpx_pkg::OP_GET_PINS, 8'hFF, 8'hFF);
		send_word(gpx_pkg::OP_SET_DIR, 8'hA5, 8'h00);
		send_word(gpx_pkg::OP_GET_PINS, 8'h00, 8'hFF);
		send_word(gpx_pkg::OP_SET_OUT, 8'hFF, 8'h00);
		send_word(gpx_pkg::OP_SET_PULLUP, 8'hFF, 8'h00);
		send_word(gpx_pkg::OP_SET_IRQ_EN, 8'hFF, 8'h00);
		send_word(gpx_pkg::OP_EVENT_LOW, 8'hFF, 8'hFF);
		send_word(gpx_pkg::OP_EVENT_HIGH, 8'hFF, 8'h00);
		send_word(gpx_pkg::OP_GET_FLAGS, 8'h00, 8'h00);
		send_word(gpx_pkg::OP_GET_FLAGS, 8'h00, 8'h00);
		send_word(gpx_pkg::OP_SET_IRQ_EN, 8'h81, 8'h00);
		send_word(gpx_pkg::OP_EVENT_LOW, 8'h3F, 8'h00);
		send_word(gpx_pkg::OP_EVENT_HIGH, 8'h03, 8'h00);
		send_word(gpx_pkg::OP_GET_FLAGS, 8'h00, 8'h00);
		send_word(gpx_pkg::OP_GET_COUNT, 8'h00, 8'h00);
		send_word(gpx_pkg::OP_GET_COUNT, gpx_pkg::LAST_INDEX, 8'h00);
		send_word(gpx_pkg::OP_GET_COUNT, 8'h08, 8'h00);
		send_word(gpx_pkg::OP_GET_COUNT, 8'hFF, 8'h00);
		send_word(4'd12, 8'hFF, 8'hFF);
		send_word(4'd15, 8'h00, 8'h00);
		send_word(gpx_pkg::OP_RESET, 8'hFF, 8'hFF);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 64 == 0) send_mode = $urandom_range(0, 2);
			send_random_word();
		end
		in_valid <= 1'b0;

		while (book.pending() > 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (book.errors == 0) begin
			$display("gpio_expander_irq_counter test passed");
		end else begin
			$display("gpio_expander_irq_counter test failed");
		end
		$finish;
	end
endmodule
